### rtl/vcu_pkg.sv
// ----------------------------------------------------------------------------
// vcu_pkg
// Shared types and codes for the vector clock unit: request and result
// layouts, operation, merge mode, answer and register codes.
// ----------------------------------------------------------------------------
package vcu_pkg;

	localparam logic [2:0] OP_TICK_OWN = 3'd0;
	localparam logic [2:0] OP_TICK_IDX = 3'd1;
	localparam logic [2:0] OP_MERGE    = 3'd2;
	localparam logic [2:0] OP_COMPARE  = 3'd3;
	localparam logic [2:0] OP_UNIQUE   = 3'd4;
	localparam logic [2:0] OP_READ     = 3'd5;

	localparam logic [1:0] MERGE_ALL      = 2'd0;
	localparam logic [1:0] MERGE_SELECTED = 2'd1;
	localparam logic [1:0] MERGE_OTHERS   = 2'd2;

	localparam logic [1:0] ANS_COMPARE = 2'd0;
	localparam logic [1:0] ANS_UNIQUE  = 2'd1;
	localparam logic [1:0] ANS_READ    = 2'd2;

	localparam logic REG_OWN_THREAD   = 1'b0;
	localparam logic REG_THREAD_COUNT = 1'b1;

	localparam int CFG_DATA_W = 7;

	typedef struct packed {
		logic [2:0]  operation;
		logic [5:0]  index;
		logic [31:0] value;
		logic [1:0]  merge_mode;
		logic [5:0]  selected_index;
		logic        last;
	} req_t;

	typedef struct packed {
		logic [1:0]  answer_kind;
		logic        local_before;
		logic        remote_before;
		logic        equal;
		logic        concurrent;
		logic        unique_res;
		logic [31:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic le;
		logic ge;
		logic lt;
		logic gt;
	} cmp_flags_t;

	typedef struct packed {
		logic wr_en;
		logic rsp_valid;
	} alu_ctl_t;

endpackage

### rtl/vector_clock_unit.sv
// ----------------------------------------------------------------------------
// vector_clock_unit
// Vector clock of one thread: one wrapping counter per thread in a
// synchronous RAM, with tick, merge, compare, unique query and read.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req when start is high and busy is low. The counter
//   RAM is read into a register at the accepting edge and the modified
//   entry is written back in the cycle after, while busy is high; no new
//   request is taken until the write-back is done.
//   Compare (last element), unique query and read give one result on rsp,
//   marked by done for exactly one cycle; rsp and done are registered at
//   the write-back edge. The receiver cannot stall; a result is always
//   taken. Other operations give no result.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr at once;
//   write only while no request is in flight.
//   Reset: all counters read as zero (a per-entry nonzero bit marks entries
//   that hold a value, so no clearing pass is needed), compare flags are
//   restarted, own_thread is 0 and thread_count is 64.
// ----------------------------------------------------------------------------
module vector_clock_unit #(
	parameter int MAX_THREADS = 64,
	parameter int COUNT_BITS  = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  vcu_pkg::req_t                     req,
	output logic                              done,
	output vcu_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic                              cfg_addr,
	input  logic [vcu_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import vcu_pkg::*;

	localparam int AW = $clog2(MAX_THREADS);

	logic [COUNT_BITS-1:0]  mem [MAX_THREADS];

	logic [5:0]             own_thread_q;
	logic [6:0]             thread_count_q;
	logic [MAX_THREADS-1:0] nonzero_q;
	cmp_flags_t             flags_q;
	logic                   busy_q;
	logic                   done_q;
	rsp_t                   rsp_q;

	req_t                   req_s1;
	logic [AW-1:0]          addr_s1;
	logic                   in_range_s1;
	logic [COUNT_BITS-1:0]  rd_s1;

	logic                   accept;
	logic [5:0]             eidx;
	logic                   in_range_d;
	logic [MAX_THREADS-1:0] busy_mask;
	logic                   uniq;
	logic [COUNT_BITS-1:0]  loc;
	logic [COUNT_BITS-1:0]  wr_data;
	cmp_flags_t             flags_next;
	alu_ctl_t               ctl;
	rsp_t                   alu_rsp;

	assign accept     = start & ~busy_q;
	assign eidx       = (req.operation == OP_TICK_OWN) ? own_thread_q : req.index;
	assign in_range_d = (32'(eidx) < 32'(thread_count_q)) && (32'(eidx) < 32'(MAX_THREADS));

	// entries in use, other than the queried one, that hold a nonzero count
	always_comb begin
		for (int i = 0; i < MAX_THREADS; i++) begin
			busy_mask[i] = nonzero_q[i] && (32'(i) < 32'(thread_count_q)) &&
			               (32'(i) != 32'(req_s1.index));
		end
	end
	assign uniq = ~|busy_mask;
	assign loc  = nonzero_q[addr_s1] ? rd_s1 : '0;

	vcu_alu #(
		.COUNT_BITS (COUNT_BITS)
	) u_alu (
		.req        (req_s1),
		.in_range   (in_range_s1),
		.uniq       (uniq),
		.loc        (loc),
		.flags      (flags_q),
		.wr_data    (wr_data),
		.flags_next (flags_next),
		.ctl        (ctl),
		.rsp        (alu_rsp)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1       <= mem[AW'(eidx)];
			req_s1      <= req;
			addr_s1     <= AW'(eidx);
			in_range_s1 <= in_range_d;
		end
		if (busy_q && ctl.wr_en) begin
			mem[addr_s1] <= wr_data;
		end
		if (busy_q && ctl.rsp_valid) begin
			rsp_q <= alu_rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_thread_q   <= '0;
			thread_count_q <= 7'd64;
			nonzero_q      <= '0;
			flags_q        <= '{le: 1'b1, ge: 1'b1, lt: 1'b0, gt: 1'b0};
			busy_q         <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_addr)
					REG_OWN_THREAD:   own_thread_q   <= cfg_wdata[5:0];
					REG_THREAD_COUNT: thread_count_q <= cfg_wdata[6:0];
					default:          own_thread_q   <= own_thread_q;
				endcase
			end
			busy_q <= accept;
			done_q <= busy_q & ctl.rsp_valid;
			if (busy_q) begin
				flags_q <= flags_next;
				if (ctl.wr_en) begin
					nonzero_q[addr_s1] <= |wr_data;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/vcu_alu.sv
// ----------------------------------------------------------------------------
// vcu_alu
// Modify step of the read-modify-write: tick, merge by maximum, compare
// flag update and answer formatting for one request.
// ----------------------------------------------------------------------------
module vcu_alu #(
	parameter int COUNT_BITS = 32
) (
	input  vcu_pkg::req_t       req,
	input  logic                in_range,
	input  logic                uniq,
	input  logic [COUNT_BITS-1:0] loc,
	input  vcu_pkg::cmp_flags_t flags,
	output logic [COUNT_BITS-1:0] wr_data,
	output vcu_pkg::cmp_flags_t flags_next,
	output vcu_pkg::alu_ctl_t   ctl,
	output vcu_pkg::rsp_t       rsp
);
	import vcu_pkg::*;

	logic [COUNT_BITS-1:0] val;
	logic                  take;
	cmp_flags_t            fl;
	logic                  lb;
	logic                  rb;

	assign val = COUNT_BITS'(req.value);

	always_comb begin
		take = 1'b0;
		case (req.merge_mode)
			MERGE_ALL:      take = 1'b1;
			MERGE_SELECTED: take = (req.index == req.selected_index);
			MERGE_OTHERS:   take = (req.index != req.selected_index);
			default:        take = 1'b0;
		endcase
	end

	always_comb begin
		fl = flags;
		if (in_range) begin
			if (loc > val) begin
				fl.le = 1'b0;
				fl.gt = 1'b1;
			end
			if (loc < val) begin
				fl.ge = 1'b0;
				fl.lt = 1'b1;
			end
		end
		lb = fl.le & fl.lt;
		rb = fl.ge & fl.gt;
	end

	always_comb begin
		wr_data       = loc + COUNT_BITS'(1);
		flags_next    = flags;
		ctl.wr_en     = 1'b0;
		ctl.rsp_valid = 1'b0;
		rsp           = '0;
		case (req.operation)
			OP_TICK_OWN, OP_TICK_IDX: begin
				ctl.wr_en = in_range;
			end
			OP_MERGE: begin
				wr_data   = val;
				ctl.wr_en = in_range & take & (val > loc);
			end
			OP_COMPARE: begin
				flags_next = fl;
				if (req.last) begin
					ctl.rsp_valid     = 1'b1;
					rsp.answer_kind   = ANS_COMPARE;
					rsp.local_before  = lb;
					rsp.remote_before = rb;
					rsp.equal         = fl.le & fl.ge;
					rsp.concurrent    = ~lb & ~rb;
					flags_next        = '{le: 1'b1, ge: 1'b1, lt: 1'b0, gt: 1'b0};
				end
			end
			OP_UNIQUE: begin
				ctl.rsp_valid   = 1'b1;
				rsp.answer_kind = ANS_UNIQUE;
				rsp.unique_res  = uniq;
			end
			OP_READ: begin
				ctl.rsp_valid   = 1'b1;
				rsp.answer_kind = ANS_READ;
				rsp.read_value  = in_range ? 32'(loc) : 32'd0;
			end
			default: begin
				ctl.wr_en = 1'b0;
			end
		endcase
	end

endmodule

### rtl/vcu_checker.sv
// ----------------------------------------------------------------------------
// vcu_checker
// Port-level checks on the vector clock unit: request/result timing and
// consistency of compare answers.
// ----------------------------------------------------------------------------
module vcu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input vcu_pkg::rsp_t rsp
);
	import vcu_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done)
		else $error("accepted request did not raise busy");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held longer than one cycle");

	a_done_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy ##1 !done)
		else $error("results closer than request spacing");

	a_cmp_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.answer_kind == ANS_COMPARE |->
			$onehot({rsp.local_before, rsp.remote_before, rsp.concurrent}) &&
			(!rsp.equal || rsp.concurrent))
		else $error("inconsistent compare verdict");

	a_kind_valid: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rsp.answer_kind == ANS_COMPARE || rsp.answer_kind == ANS_UNIQUE ||
			rsp.answer_kind == ANS_READ && !rsp.unique_res)
		else $error("bad answer kind or stray field");

endmodule

bind vector_clock_unit vcu_checker u_vcu_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

### tb/vector_clock_unit_tb.sv
// ----------------------------------------------------------------------------
// vector_clock_unit_tb
// Self-checking bench for the vector clock unit. A directed pass covers every
// operation, counter wrap, the merge modes and partial thread counts; random
// phases then run compare vectors, merges, ticks, reads and queries under
// several register settings and sender idle rates. Answers are checked against
// a shadow copy of the clock kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector_clock_unit_tb;
	import vcu_pkg::*;

	localparam logic [2:0] OP_SPARE_6 = 3'd6;
	localparam logic [2:0] OP_SPARE_7 = 3'd7;
	localparam logic [1:0] MERGE_NONE = 2'd3;
	localparam int         RUN_LIMIT  = 200000;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	req_t                  req       = '0;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_addr  = REG_OWN_THREAD;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  busy;
	logic                  done;
	rsp_t                  rsp;

	// shadow of the unit
	logic [31:0]           vclock [64];
	cmp_flags_t            cmp_run;
	logic [5:0]            owner_idx;
	logic [6:0]            entries_cfg;

	rsp_t                  answers_due [$];
	int                    idle_pct        = 0;
	int                    requests_sent   = 0;
	int                    reg_writes      = 0;
	int                    answers_checked = 0;
	int                    mismatches      = 0;
	int                    ordered_verdicts = 0;
	int                    unique_hits     = 0;

	vector_clock_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (RUN_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles, %0d answers outstanding", RUN_LIMIT,
			answers_due.size());
		$display("TB_ERROR");
		$finish;
	end

	function automatic int entries_in_use();
		return (entries_cfg > 7'd64) ? 64 : int'(entries_cfg);
	endfunction

	// apply one accepted request to the shadow clock, queue its answer if any
	task automatic advance_vclock(input req_t r);
		int   n;
		int   j;
		rsp_t a;
		logic lb;
		logic rb;
		n = entries_in_use();
		a = '0;
		case (r.operation)
			OP_TICK_OWN: begin
				if (int'(owner_idx) < n) vclock[owner_idx] = vclock[owner_idx] + 32'd1;
			end
			OP_TICK_IDX: begin
				if (int'(r.index) < n) vclock[r.index] = vclock[r.index] + 32'd1;
			end
			OP_MERGE: begin
				if (int'(r.index) < n &&
						(r.merge_mode == MERGE_ALL ||
						(r.merge_mode == MERGE_SELECTED && r.index == r.selected_index) ||
						(r.merge_mode == MERGE_OTHERS && r.index != r.selected_index)) &&
						r.value > vclock[r.index])
					vclock[r.index] = r.value;
			end
			OP_COMPARE: begin
				if (int'(r.index) < n) begin
					if (vclock[r.index] > r.value) begin
						cmp_run.le = 1'b0;
						cmp_run.gt = 1'b1;
					end
					if (vclock[r.index] < r.value) begin
						cmp_run.ge = 1'b0;
						cmp_run.lt = 1'b1;
					end
				end
				if (r.last) begin
					lb = cmp_run.le & cmp_run.lt;
					rb = cmp_run.ge & cmp_run.gt;
					a.answer_kind   = ANS_COMPARE;
					a.local_before  = lb;
					a.remote_before = rb;
					a.equal         = cmp_run.le & cmp_run.ge;
					a.concurrent    = ~lb & ~rb;
					if (lb | rb) ordered_verdicts++;
					answers_due.push_back(a);
					cmp_run = '{le: 1'b1, ge: 1'b1, lt: 1'b0, gt: 1'b0};
				end
			end
			OP_UNIQUE: begin
				a.answer_kind = ANS_UNIQUE;
				a.unique_res  = 1'b1;
				for (j = 0; j < n; j++)
					if (j != int'(r.index) && vclock[j] != 32'd0) a.unique_res = 1'b0;
				if (a.unique_res) unique_hits++;
				answers_due.push_back(a);
			end
			OP_READ: begin
				a.answer_kind = ANS_READ;
				if (int'(r.index) < n) a.read_value = vclock[r.index];
				answers_due.push_back(a);
			end
			default: ;
		endcase
	endtask

	function automatic string fmt_answer(input rsp_t a);
		return $sformatf("kind=%0d lb=%0b rb=%0b eq=%0b cc=%0b uq=%0b val=%08h",
			a.answer_kind, a.local_before, a.remote_before, a.equal, a.concurrent,
			a.unique_res, a.read_value);
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) $display("MISMATCH: %s", msg);
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (answers_due.size() == 0) begin
				log_mismatch($sformatf("answer with none due: %s", fmt_answer(rsp)));
			end else begin
				want = answers_due.pop_front();
				answers_checked++;
				if (rsp.answer_kind !== want.answer_kind ||
						rsp.local_before !== want.local_before ||
						rsp.remote_before !== want.remote_before ||
						rsp.equal !== want.equal ||
						rsp.concurrent !== want.concurrent ||
						rsp.unique_res !== want.unique_res ||
						rsp.read_value !== want.read_value)
					log_mismatch($sformatf("answer %0d expected %s got %s", answers_checked,
						fmt_answer(want), fmt_answer(rsp)));
			end
		end
	end

	// hold the request until accepted, then maybe leave a gap
	task automatic send_request(input req_t r);
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		advance_vclock(r);
		requests_sent++;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic issue(input logic [2:0] op, input logic [5:0] idx, input logic [31:0] val,
			input logic [1:0] mode, input logic [5:0] sel, input logic lst);
		req_t r;
		r.operation      = op;
		r.index          = idx;
		r.value          = val;
		r.merge_mode     = mode;
		r.selected_index = sel;
		r.last           = lst;
		send_request(r);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_OWN_THREAD) owner_idx = data[5:0];
		else entries_cfg = data;
		reg_writes++;
	endtask

	function automatic req_t blank_req();
		req_t r;
		r.operation      = 3'($urandom_range(0, 7));
		r.index          = 6'($urandom_range(0, 63));
		r.value          = $urandom;
		r.merge_mode     = 2'($urandom_range(0, 3));
		r.selected_index = 6'($urandom_range(0, 63));
		r.last           = 1'($urandom_range(0, 1));
		return r;
	endfunction

	function automatic logic [5:0] pick_index();
		int n;
		n = entries_in_use();
		if (n > 0 && $urandom_range(0, 9) != 0) return 6'($urandom_range(0, n - 1));
		return 6'($urandom_range(0, 63));
	endfunction

	// tick, merge, read or query with plausible operands
	task automatic misc_request();
		req_t r;
		int   pick;
		r = blank_req();
		r.index = pick_index();
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			r.operation = OP_MERGE;
			case ($urandom_range(0, 3))
				0: r.value = $urandom;
				1: r.value = 32'hFFFF_FFFF - 32'($urandom_range(0, 2));
				default: r.value = vclock[r.index] + 32'($urandom_range(0, 3)) - 32'd1;
			endcase
			r.merge_mode = ($urandom_range(0, 15) == 0) ? MERGE_NONE : 2'($urandom_range(0, 2));
			if ($urandom_range(0, 1) == 0) r.selected_index = r.index;
		end else if (pick < 6) begin
			r.operation = ($urandom_range(0, 1) == 0) ? OP_TICK_OWN : OP_TICK_IDX;
		end else if (pick < 8) begin
			r.operation = OP_READ;
		end else begin
			r.operation = OP_UNIQUE;
		end
		send_request(r);
	endtask

	// one received vector, element by element, leaning toward a chosen verdict
	task automatic compare_run();
		int          n;
		int          len;
		int          lean;
		int          k;
		logic        sweep;
		req_t        r;
		logic [31:0] loc;
		n = entries_in_use();
		sweep = (n > 0 && $urandom_range(0, 7) == 0);
		len = sweep ? n : $urandom_range(1, 6);
		lean = $urandom_range(0, 3);
		for (k = 0; k < len; k++) begin
			r = blank_req();
			r.operation = OP_COMPARE;
			r.index = sweep ? 6'(k) : pick_index();
			loc = vclock[r.index];
			case (lean)
				0: r.value = loc;
				1: r.value = loc + 32'($urandom_range(0, 1));
				2: r.value = loc - 32'($urandom_range(0, 1));
				default: r.value = ($urandom_range(0, 3) == 0) ? $urandom :
					loc + 32'($urandom_range(0, 4)) - 32'd2;
			endcase
			r.last = (k == len - 1);
			send_request(r);
			if (k != len - 1 && $urandom_range(0, 9) == 0) misc_request();
		end
	endtask

	// bring one entry back to zero through wrap
	task automatic wrap_entry(input logic [5:0] idx);
		issue(OP_MERGE, idx, 32'hFFFF_FFFF, MERGE_ALL, 6'($urandom_range(0, 63)), 1'b0);
		issue(OP_TICK_IDX, idx, $urandom, 2'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
			1'b1);
	endtask

	task automatic test_directed_ops();
		issue(OP_READ, 6'd63, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_UNIQUE, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b1);
		issue(OP_TICK_OWN, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_TICK_IDX, 6'd63, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_MERGE, 6'd5, 32'hFFFF_FFFF, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd5, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_TICK_IDX, 6'd5, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_MERGE, 6'd7, 32'd100, MERGE_SELECTED, 6'd7, 1'b0);
		issue(OP_MERGE, 6'd8, 32'd100, MERGE_SELECTED, 6'd7, 1'b0);
		issue(OP_MERGE, 6'd9, 32'd50, MERGE_OTHERS, 6'd7, 1'b0);
		issue(OP_MERGE, 6'd7, 32'd500, MERGE_OTHERS, 6'd7, 1'b0);
		issue(OP_MERGE, 6'd7, 32'd20, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_MERGE, 6'd10, 32'd77, MERGE_NONE, 6'd10, 1'b0);
		issue(OP_SPARE_6, 6'd11, 32'hFFFF_FFFF, MERGE_ALL, 6'd11, 1'b1);
		issue(OP_SPARE_7, 6'd11, 32'hFFFF_FFFF, MERGE_ALL, 6'd11, 1'b1);
		issue(OP_UNIQUE, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd7, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd8, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd9, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd10, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		// mixed vector with a read in the middle -> concurrent
		issue(OP_COMPARE, 6'd0, 32'd1, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd7, 32'd200, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd63, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd9, 32'd10, MERGE_ALL, 6'd0, 1'b1);
		issue(OP_COMPARE, 6'd7, 32'd100, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd63, 32'd2, MERGE_ALL, 6'd0, 1'b1);
		issue(OP_COMPARE, 6'd7, 32'd99, MERGE_ALL, 6'd0, 1'b1);
	endtask

	task automatic test_partial_use();
		write_reg(REG_THREAD_COUNT, 7'd4);
		write_reg(REG_OWN_THREAD, 7'd10);
		issue(OP_TICK_OWN, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_TICK_IDX, 6'd20, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_MERGE, 6'd20, 32'd9, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd20, 32'd5, MERGE_ALL, 6'd0, 1'b1);
		issue(OP_READ, 6'd20, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_UNIQUE, 6'd40, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_UNIQUE, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		write_reg(REG_THREAD_COUNT, 7'd0);
		issue(OP_UNIQUE, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_TICK_IDX, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_COMPARE, 6'd0, 32'd3, MERGE_ALL, 6'd0, 1'b1);
		write_reg(REG_OWN_THREAD, 7'h7F);
		write_reg(REG_THREAD_COUNT, 7'h7F);
		issue(OP_TICK_OWN, 6'd0, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_READ, 6'd63, 32'd0, MERGE_ALL, 6'd0, 1'b0);
		issue(OP_UNIQUE, 6'd63, 32'd0, MERGE_ALL, 6'd0, 1'b0);
	endtask

	task automatic test_random_phase(input logic [5:0] own, input logic [6:0] count,
			input int pct, input int quota);
		int   first;
		int   kind;
		req_t r;
		write_reg(REG_OWN_THREAD, {1'b0, own});
		write_reg(REG_THREAD_COUNT, count);
		idle_pct = pct;
		first = requests_sent;
		while (requests_sent - first < quota) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				compare_run();
			end else if (kind < 83) begin
				misc_request();
			end else if (kind < 88) begin
				wrap_entry(pick_index());
			end else begin
				r = blank_req();
				send_request(r);
			end
		end
		drain();
		idle_pct = 0;
	endtask

	initial begin
		for (int i = 0; i < 64; i++) vclock[i] = 32'd0;
		cmp_run     = '{le: 1'b1, ge: 1'b1, lt: 1'b0, gt: 1'b0};
		owner_idx   = 6'd0;
		entries_cfg = 7'd64;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_ops();
		test_partial_use();
		test_random_phase(6'd3, 7'd64, 0, 320);
		test_random_phase(6'd17, 7'd8, 81, 300);
		test_random_phase(6'd63, 7'd64, 21, 320);
		test_random_phase(6'd0, 7'd1, 81, 220);
		test_random_phase(6'd40, 7'd2, 0, 220);
		test_random_phase(6'd9, 7'd33, 21, 220);
		drain();

		$display("%0d requests over %0d register writes, %0d answers checked",
			requests_sent, reg_writes, answers_checked);
		$display("%0d ordered compare verdicts, %0d unique queries true, %0d mismatches",
			ordered_verdicts, unique_hits, mismatches);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

### sim.f
rtl/vcu_pkg.sv
rtl/vcu_alu.sv
rtl/vector_clock_unit.sv
rtl/vcu_checker.sv
tb/vector_clock_unit_tb.sv
